### design/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions of the SHA-1 byte hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int DigestWords = 5;
  localparam int BlockWords  = 16;
  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [5:0] LastBytePos = 6'd63;
  localparam logic [5:0] LengthPos = 6'd56;

  localparam logic [31:0] InitHash [DigestWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic       push;
    byte_sel_t  byte_sel;
    logic       count_bits;
    logic       load_vars;
    logic       round_en;
    logic [6:0] round;
    logic       finalize;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       out_busy;
  } sts_t;

  function automatic logic [31:0] sha1_k(input logic [6:0] r);
    logic [31:0] k;
    if (r inside {[7'd0:7'd19]}) begin
      k = 32'h5A827999;
    end else if (r inside {[7'd20:7'd39]}) begin
      k = 32'h6ED9EBA1;
    end else if (r inside {[7'd40:7'd59]}) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] sha1_f(input logic [6:0] r, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r inside {[7'd0:7'd19]}) begin
      f = (b & c) | (~b & d);
    end else if (r inside {[7'd40:7'd59]}) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

### design/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl
// Controller: sequences byte intake, padding, compression rounds and digest
// hand-off, driving the datapath through a command struct.
// ----------------------------------------------------------------------------
module sha1_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            last_byte,
  input  logic            empty_message,
  input  sha1_pkg::sts_t  sts,
  output sha1_pkg::cmd_t  cmd
);
  import sha1_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_PAD      = 5'b00010,
    ST_COMPRESS = 5'b00100,
    ST_FINAL    = 5'b01000,
    ST_DONE     = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [6:0] round_cnt, round_cnt_next;
  logic       sent80, sent80_next;
  logic       second, second_next;
  logic       pad_pending, pad_pending_next;
  logic       done_pending, done_pending_next;
  logic       is_len;

  assign in_ready = (state == ST_IDLE);
  assign is_len = sent80 && !second && (sts.pos >= LengthPos);

  always_comb begin
    state_next        = state;
    round_cnt_next    = round_cnt;
    sent80_next       = sent80;
    second_next       = second;
    pad_pending_next  = pad_pending;
    done_pending_next = done_pending;
    cmd               = '0;
    cmd.byte_sel      = SEL_DATA;
    cmd.round         = round_cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sent80_next = 1'b0;
          second_next = 1'b0;
          if (empty_message) begin
            state_next = ST_PAD;
          end else begin
            cmd.push       = 1'b1;
            cmd.count_bits = 1'b1;
            if (sts.pos == LastBytePos) begin
              cmd.load_vars     = 1'b1;
              round_cnt_next    = '0;
              pad_pending_next  = last_byte;
              done_pending_next = 1'b0;
              state_next        = ST_COMPRESS;
            end else if (last_byte) begin
              state_next = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        cmd.push    = 1'b1;
        sent80_next = 1'b1;
        if (!sent80) begin
          cmd.byte_sel = SEL_PAD;
        end else if (is_len) begin
          cmd.byte_sel = SEL_LEN;
        end else begin
          cmd.byte_sel = SEL_ZERO;
        end
        if (sts.pos == LastBytePos) begin
          second_next       = 1'b0;
          cmd.load_vars     = 1'b1;
          round_cnt_next    = '0;
          done_pending_next = is_len;
          pad_pending_next  = !is_len;
          state_next        = ST_COMPRESS;
        end else if (!sent80) begin
          second_next = (sts.pos >= LengthPos);
        end
      end
      ST_COMPRESS: begin
        cmd.round_en = 1'b1;
        if (round_cnt == LastRound) begin
          state_next = ST_FINAL;
        end else begin
          round_cnt_next = round_cnt + 7'd1;
        end
      end
      ST_FINAL: begin
        cmd.finalize   = 1'b1;
        round_cnt_next = '0;
        if (done_pending) begin
          state_next = ST_DONE;
        end else if (pad_pending) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit          = 1'b1;
          done_pending_next = 1'b0;
          pad_pending_next  = 1'b0;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      round_cnt    <= '0;
      sent80       <= 1'b0;
      second       <= 1'b0;
      pad_pending  <= 1'b0;
      done_pending <= 1'b0;
    end else begin
      state        <= state_next;
      round_cnt    <= round_cnt_next;
      sent80       <= sent80_next;
      second       <= second_next;
      pad_pending  <= pad_pending_next;
      done_pending <= done_pending_next;
    end
  end

endmodule

### design/sha1_datapath.sv
// ----------------------------------------------------------------------------
// sha1_datapath
// Datapath: byte packing, rolling message schedule, round unit, chaining
// hash, bit count and the digest output buffer.
// ----------------------------------------------------------------------------
module sha1_datapath (
  input  logic            clk,
  input  logic            rst,
  input  sha1_pkg::cmd_t  cmd,
  output sha1_pkg::sts_t  sts,
  input  logic [7:0]      data_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     digest_word,
  output logic [2:0]      word_index,
  output logic            last_word
);
  import sha1_pkg::*;

  logic [5:0]  pos;
  logic [63:0] bit_length;
  logic [23:0] acc;
  logic [31:0] sched [BlockWords];
  logic [31:0] hash_words [DigestWords];
  logic [31:0] vars [DigestWords];
  logic [31:0] obuf [DigestWords];
  logic [2:0]  out_cnt;

  logic [7:0]  byte_in;
  logic [5:0]  len_shift;
  logic [31:0] sched_new;
  logic [31:0] tmp;

  assign len_shift = {3'd7 - pos[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      SEL_DATA: byte_in = data_byte;
      SEL_PAD:  byte_in = 8'h80;
      SEL_ZERO: byte_in = 8'h00;
      SEL_LEN:  byte_in = 8'(bit_length >> len_shift);
      default:  byte_in = 8'h00;
    endcase
  end

  always_comb begin
    sched_new = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
    sched_new = {sched_new[30:0], sched_new[31]};
    tmp = {vars[0][26:0], vars[0][31:27]} + sha1_f(cmd.round, vars[1], vars[2], vars[3])
          + vars[4] + sha1_k(cmd.round) + sched[0];
  end

  assign sts.pos      = pos;
  assign sts.out_busy = out_valid;
  assign digest_word  = obuf[0];
  assign word_index   = out_cnt;
  assign last_word    = (out_cnt == 3'(DigestWords - 1));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (pos[1:0] == 2'd3) begin
        for (int i = 0; i < BlockWords - 1; i++) begin
          sched[i] <= sched[i + 1];
        end
        sched[BlockWords - 1] <= {acc, byte_in};
      end else begin
        acc <= {acc[15:0], byte_in};
      end
    end
    if (cmd.round_en) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[BlockWords - 1] <= sched_new;
      vars[0] <= tmp;
      vars[1] <= vars[0];
      vars[2] <= {vars[1][1:0], vars[1][31:2]};
      vars[3] <= vars[2];
      vars[4] <= vars[3];
    end
    if (cmd.load_vars) begin
      for (int i = 0; i < DigestWords; i++) begin
        vars[i] <= hash_words[i];
      end
    end
    if (cmd.emit) begin
      for (int i = 0; i < DigestWords; i++) begin
        obuf[i] <= hash_words[i];
      end
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < DigestWords - 1; i++) begin
        obuf[i] <= obuf[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      bit_length <= '0;
      out_valid  <= 1'b0;
      out_cnt    <= '0;
      for (int i = 0; i < DigestWords; i++) begin
        hash_words[i] <= InitHash[i];
      end
    end else begin
      if (cmd.push) begin
        pos <= pos + 6'd1;
      end
      if (cmd.count_bits) begin
        bit_length <= bit_length + 64'd8;
      end
      if (cmd.finalize) begin
        for (int i = 0; i < DigestWords; i++) begin
          hash_words[i] <= hash_words[i] + vars[i];
        end
      end
      if (cmd.emit) begin
        pos        <= '0;
        bit_length <= '0;
        out_valid  <= 1'b1;
        out_cnt    <= '0;
        for (int i = 0; i < DigestWords; i++) begin
          hash_words[i] <= InitHash[i];
        end
      end else if (out_valid && out_ready) begin
        out_cnt <= out_cnt + 3'd1;
        if (out_cnt == 3'(DigestWords - 1)) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

endmodule

### design/sha1_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_core
// SHA-1 hasher taking one message byte per beat and returning the digest as
// five 32-bit words, most significant first.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid/in_ready    data_byte, last_byte, empty_message
//  out      source     out_valid/out_ready  digest_word, word_index, last_word
//
// A byte that fills a 64-byte block starts a compression: 80 rounds of the
// single round unit, then one chaining add.
// Ending a message pushes padding and length bytes one per cycle, runs one or
// two compressions and loads the digest buffer, which drains one word a cycle
// while out_ready is high. Reset is synchronous. Bytes are taken while the
// digest buffer drains; a finished digest waits until the buffer is empty.
module sha1_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        empty_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sha1_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .last_byte     (last_byte),
    .empty_message (empty_message),
    .sts           (sts),
    .cmd           (cmd)
  );

  sha1_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule
